/* rtl/ovl_pkg.sv */
// Shared constants and codes for the ordered value list.
`timescale 1ns / 1ps

package ovl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int REQ_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = 5;

    localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

/* rtl/ordered_value_list.sv */
// Ordered value list: insertion-ordered store with append, remove and search.
//
// Input channel: i_in_valid / o_in_stall carries one request transaction
// (i_req_type, i_item_value). o_in_stall is high while a request is being
// worked on, so requests are taken one at a time.
// Output channel: o_out_valid / i_out_stall carries one result transaction
// (o_status, o_entry_count) per request, held in an output register.
// A new request is taken while an earlier result still waits in it.
// Append, no-op and refused requests go from idle straight to the response
// state and on to the result register. Search walks the stored entries
// through one read port and one comparator at one entry per cycle. Remove
// continues from the match with a compaction pass through the same port,
// one entry moved per cycle; the entry just past the match is read again
// at the start of the pass. The single memory read port and the shared
// comparator set this pace.
// While the receiver stalls, a finished result waits in the sequencer
// before the output register frees up; the next request is not taken then.
// Reset clears the entry count and all handshake state; stored entries
// are not cleared, and only entries below the count are ever compared or moved.
`timescale 1ns / 1ps

module ordered_value_list (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [ovl_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [ovl_pkg::VALUE_W-1:0]  i_item_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [ovl_pkg::STATUS_W-1:0]        o_status,
    output logic [ovl_pkg::ENTRY_W-1:0]         o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_RESP
    } t_state;

    localparam int IDX_W = ovl_pkg::IDX_W;
    localparam int CNT_W = ovl_pkg::CNT_W;

    // entry store
    logic [ovl_pkg::VALUE_W-1:0] r_mem [ovl_pkg::CAPACITY];
    logic [ovl_pkg::VALUE_W-1:0] r_rd_data;

    t_state                          r_state,      n_state;
    logic [CNT_W-1:0]                r_count,      n_count;
    logic [CNT_W-1:0]                r_rd_idx,     n_rd_idx;
    logic [CNT_W-1:0]                r_dv_idx,     n_dv_idx;
    logic                            r_dv,         n_dv;
    logic [ovl_pkg::REQ_W-1:0]       r_req,        n_req;
    logic [ovl_pkg::VALUE_W-1:0]     r_value,      n_value;
    logic [ovl_pkg::STATUS_W-1:0]    r_res_status, n_res_status;
    logic                            r_out_valid,  n_out_valid;
    logic [ovl_pkg::STATUS_W-1:0]    r_status,     n_status;
    logic [ovl_pkg::ENTRY_W-1:0]     r_entry_cnt,  n_entry_cnt;

    logic                            mem_we;
    logic [IDX_W-1:0]                mem_waddr;
    logic [ovl_pkg::VALUE_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]                rd_addr;
    logic                            in_take;
    logic                            out_free;
    logic                            dv_last;
    logic                            dv_hit;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign rd_addr  = r_rd_idx[IDX_W-1:0];
    assign dv_hit   = r_dv && (r_rd_data == r_value);
    assign dv_last  = r_dv && (CNT_W'(r_dv_idx + 1'b1) == r_count);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_idx     = r_rd_idx;
        n_dv_idx     = r_dv_idx;
        n_dv         = 1'b0;
        n_req        = r_req;
        n_value      = r_value;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_entry_cnt  = r_entry_cnt;
        mem_we       = 1'b0;
        mem_waddr    = r_count[IDX_W-1:0];
        mem_wdata    = i_item_value;

        // drop the held result once it is taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_req    = i_req_type;
                    n_value  = i_item_value;
                    n_rd_idx = '0;
                    n_state  = S_RESP;
                    case (i_req_type)
                        ovl_pkg::REQ_APPEND: begin
                            if (r_count >= CNT_W'(ovl_pkg::CAPACITY)) begin
                                n_res_status = ovl_pkg::ST_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                n_count      = CNT_W'(r_count + 1'b1);
                                n_res_status = ovl_pkg::ST_DONE;
                            end
                        end
                        ovl_pkg::REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_res_status = ovl_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        ovl_pkg::REQ_SEARCH: begin
                            if (r_count == '0) begin
                                n_res_status = ovl_pkg::ST_NOTFOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_res_status = ovl_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (dv_hit) begin
                    if (r_req == ovl_pkg::REQ_SEARCH) begin
                        n_res_status = ovl_pkg::ST_FOUND;
                        n_state      = S_RESP;
                    end else begin
                        // start compaction just past the match
                        n_rd_idx = CNT_W'(r_dv_idx + 1'b1);
                        n_dv_idx = r_dv_idx;
                        n_state  = S_SHIFT;
                    end
                end else if (dv_last) begin
                    n_res_status = ovl_pkg::ST_NOTFOUND;
                    n_state      = S_RESP;
                end else begin
                    if (r_rd_idx < r_count) begin
                        n_dv     = 1'b1;
                        n_dv_idx = r_rd_idx;
                        n_rd_idx = CNT_W'(r_rd_idx + 1'b1);
                    end
                end
            end
            S_SHIFT: begin
                // move the entry read last cycle down one place
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = IDX_W'(r_dv_idx - 1'b1);
                    mem_wdata = r_rd_data;
                end
                if (r_rd_idx >= r_count) begin
                    n_count      = CNT_W'(r_count - 1'b1);
                    n_res_status = ovl_pkg::ST_DONE;
                    n_state      = S_RESP;
                end else begin
                    n_dv     = 1'b1;
                    n_dv_idx = r_rd_idx;
                    n_rd_idx = CNT_W'(r_rd_idx + 1'b1);
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_res_status;
                    n_entry_cnt = ovl_pkg::ENTRY_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_dv_idx    <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_dv_idx    <= n_dv_idx;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_value      <= n_value;
        r_res_status <= n_res_status;
        r_status     <= n_status;
        r_entry_cnt  <= n_entry_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_entry_count = r_entry_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ovl_pkg::CAPACITY))
        else $error("entry count exceeds capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ovl_pkg::ST_FULL)
            |-> o_entry_count == ovl_pkg::ENTRY_W'(ovl_pkg::CAPACITY))
        else $error("full status with list not at capacity");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ovl_pkg::ST_EMPTY) |-> o_entry_count == '0)
        else $error("empty status with entries held");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> (r_count == CNT_W'($past(r_count) + 1'b1)
            || r_count == CNT_W'($past(r_count) - 1'b1) || $past(!i_rst_n)))
        else $error("entry count moved by more than one");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the ordered value list with random traffic and stalls.
`timescale 1ns / 1ps

module testbench;

    // Tracks the list contents as requests are accepted and queues the replies they cause.
    class list_reply_tracker;
        logic [ovl_pkg::VALUE_W-1:0]  held[ovl_pkg::CAPACITY];
        int                           held_count = 0;
        logic [ovl_pkg::STATUS_W-1:0] exp_status[$];
        logic [ovl_pkg::ENTRY_W-1:0]  exp_count[$];
        int                           mismatch_count = 0;

        function int find_first(logic [ovl_pkg::VALUE_W-1:0] v);
            for (int i = 0; i < held_count; i++) begin
                if (held[i] == v) return i;
            end
            return held_count;
        endfunction

        function void note_request(logic [ovl_pkg::REQ_W-1:0] req,
                                   logic [ovl_pkg::VALUE_W-1:0] v);
            logic [ovl_pkg::STATUS_W-1:0] st;
            int pos;
            st  = ovl_pkg::ST_DONE;
            pos = find_first(v);
            case (req)
                ovl_pkg::REQ_APPEND: begin
                    if (held_count >= ovl_pkg::CAPACITY) begin
                        st = ovl_pkg::ST_FULL;
                    end else begin
                        held[held_count] = v;
                        held_count++;
                    end
                end
                ovl_pkg::REQ_REMOVE: begin
                    if (held_count == 0) begin
                        st = ovl_pkg::ST_EMPTY;
                    end else if (pos >= held_count) begin
                        st = ovl_pkg::ST_NOTFOUND;
                    end else begin
                        // close the gap so insertion order is kept
                        for (int i = pos; i + 1 < held_count; i++) held[i] = held[i + 1];
                        held_count--;
                    end
                end
                ovl_pkg::REQ_SEARCH: begin
                    st = (pos < held_count) ? ovl_pkg::ST_FOUND : ovl_pkg::ST_NOTFOUND;
                end
                default: st = ovl_pkg::ST_DONE;
            endcase
            exp_status.push_back(st);
            exp_count.push_back(ovl_pkg::ENTRY_W'(held_count));
        endfunction

        function void check_result(logic [ovl_pkg::STATUS_W-1:0] st,
                                   logic [ovl_pkg::ENTRY_W-1:0] cnt);
            logic [ovl_pkg::STATUS_W-1:0] es;
            logic [ovl_pkg::ENTRY_W-1:0]  ec;
            if (exp_status.size() == 0) begin
                $error("result with no pending request: status %0d, entry_count %0d", st, cnt);
                mismatch_count++;
                return;
            end
            es = exp_status.pop_front();
            ec = exp_count.pop_front();
            if (st !== es) begin
                $error("status mismatch: expected %0d, actual %0d", es, st);
                mismatch_count++;
            end
            if (cnt !== ec) begin
                $error("entry_count mismatch: expected %0d, actual %0d", ec, cnt);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return exp_status.size();
        endfunction

        function int held_total();
            return held_count;
        endfunction

        function logic [ovl_pkg::VALUE_W-1:0] held_value(int idx);
            return held[idx];
        endfunction
    endclass

    localparam int RANDOM_ITEMS = 750;
    localparam int TAIL_CYCLES  = 2 * ovl_pkg::CAPACITY + 8;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic [ovl_pkg::REQ_W-1:0]           i_req_type = ovl_pkg::REQ_NOP;
    logic signed [ovl_pkg::VALUE_W-1:0]  i_item_value = '0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic [ovl_pkg::STATUS_W-1:0]        o_status;
    logic [ovl_pkg::ENTRY_W-1:0]         o_entry_count;

    list_reply_tracker tracker;

    ordered_value_list u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver stall pattern: modes of random length, from never stalling to long stall runs.
    int stall_mode = 0;
    int mode_left  = 0;
    int run_left   = 0;
    logic run_stall = 1'b0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        if (run_left == 0) begin
            run_stall = ~run_stall;
            run_left  = $urandom_range(1, 30);
        end else begin
            run_left--;
        end
        case (stall_mode)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 3) == 0);
            2:       i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= run_stall;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            tracker.check_result(o_status, o_entry_count);
        end
    end

    // Present one request, hold it until taken, then idle for the given gap, if any.
    task automatic send_request(input logic [ovl_pkg::REQ_W-1:0] req,
                                input logic [ovl_pkg::VALUE_W-1:0] v,
                                input int gap);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_item_value <= v;
        do @(posedge i_clk); while (o_in_stall);
        tracker.note_request(req, v);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // Favor values already held so remove and search hit, with edge values and noise mixed in.
    function automatic logic [ovl_pkg::VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4 && tracker.held_total() > 0) begin
            return tracker.held_value($urandom_range(0, tracker.held_total() - 1));
        end
        if (sel < 7) begin
            case ($urandom_range(0, 5))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'h0000_0001;
                default: return ovl_pkg::VALUE_W'($urandom_range(0, 7));
            endcase
        end
        return $urandom();
    endfunction

    initial begin : main_flow
        int n;
        int burst;
        int gap;
        int r;
        int append_weight;
        logic [ovl_pkg::REQ_W-1:0] req;

        tracker = new;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-list cases, edge values, duplicates, full list.
        send_request(ovl_pkg::REQ_SEARCH, 32'h0000_0000, 0);
        send_request(ovl_pkg::REQ_REMOVE, 32'h0000_0000, 1);
        send_request(ovl_pkg::REQ_APPEND, 32'h8000_0000, 0);
        send_request(ovl_pkg::REQ_APPEND, 32'h7FFF_FFFF, 0);
        send_request(ovl_pkg::REQ_APPEND, 32'h0000_0000, 2);
        send_request(ovl_pkg::REQ_APPEND, 32'hFFFF_FFFF, 0);
        send_request(ovl_pkg::REQ_APPEND, 32'h0000_0005, 0);
        send_request(ovl_pkg::REQ_APPEND, 32'h8000_0000, 3);
        send_request(ovl_pkg::REQ_SEARCH, 32'h7FFF_FFFF, 0);
        send_request(ovl_pkg::REQ_SEARCH, 32'h0000_0001, 0);
        send_request(ovl_pkg::REQ_REMOVE, 32'h8000_0000, 0);
        send_request(ovl_pkg::REQ_SEARCH, 32'h8000_0000, 1);
        send_request(ovl_pkg::REQ_REMOVE, 32'h0000_3039, 0);
        for (int i = 0; i < 11; i++) begin
            send_request(ovl_pkg::REQ_APPEND, 32'h5555_5555 ^ ovl_pkg::VALUE_W'(i), 0);
        end
        send_request(ovl_pkg::REQ_APPEND, 32'h1234_5678, 0);
        send_request(ovl_pkg::REQ_NOP, 32'hDEAD_BEEF, 0);
        send_request(ovl_pkg::REQ_REMOVE, 32'h5555_555F, 0);
        send_request(ovl_pkg::REQ_REMOVE, 32'h7FFF_FFFF, 1);

        // Random: bursts with gaps, append bias shifting to sweep between empty and full.
        n = 0;
        append_weight = 50;
        while (n < RANDOM_ITEMS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 2))
                    0:       append_weight = 15;
                    1:       append_weight = 50;
                    default: append_weight = 85;
                endcase
            end
            for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r >= 97) begin
                    req = ovl_pkg::REQ_NOP;
                end else if (r < append_weight * 97 / 100) begin
                    req = ovl_pkg::REQ_APPEND;
                end else if ($urandom_range(0, 1) == 0) begin
                    req = ovl_pkg::REQ_REMOVE;
                end else begin
                    req = ovl_pkg::REQ_SEARCH;
                end
                gap = (k == burst - 1) ? $urandom_range(1, 15) : 0;
                if (n == RANDOM_ITEMS / 2) begin
                    // hold off until every reply is back
                    send_request(req, pick_value(), 1);
                    wait_drained();
                end else begin
                    send_request(req, pick_value(), gap);
                end
                n++;
            end
        end

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
